@@ rtl/core/urd_pkg.sv @@
// Shared types for the unsigned restoring divider pipeline.
// No dependencies; compiled first.
`default_nettype none

package urd_pkg;

    // Per-stage flow control: upstream beat valid, and load enable of the stage.
    typedef struct packed {
        logic valid;
        logic load;
    } t_stage_ctrl;

endpackage : urd_pkg

`default_nettype wire

@@ rtl/core/urd_if.sv @@
// Valid/ready channel interfaces for divider operands and results.
// No dependencies beyond the language; compiled after urd_pkg.
`default_nettype none

interface urd_in_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface : urd_in_if

interface urd_out_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink   (input valid, input quotient, input remainder, output ready);
endinterface : urd_out_if

`default_nettype wire

@@ rtl/core/unsigned_restoring_divider_core.sv @@
// Unsigned restoring divider, DATA_WIDTH stages, one quotient bit per stage.
// Beats pass the stage registers in order; each register frees as its beat moves on.
// Throughput: one beat per cycle while the output accepts results.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
// Depends on urd_pkg, urd_in_if, urd_out_if and urd_stage.
`default_nettype none

module unsigned_restoring_divider_core #(
    parameter int DATA_WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    urd_in_if.sink     i_in,
    urd_out_if.source  o_out
);
    import urd_pkg::*;

    logic [DATA_WIDTH-1:0] rem_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] num_s [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] den_s [0:DATA_WIDTH];
    logic [DATA_WIDTH:0]   valid_s;
    logic [DATA_WIDTH:0]   load_s;
    t_stage_ctrl           ctrl_s [0:DATA_WIDTH-1];

    assign rem_s[0]   = '0;
    assign num_s[0]   = i_in.dividend;
    assign den_s[0]   = i_in.divisor;
    assign valid_s[0] = i_in.valid;

    // a stage loads when it is empty or its beat moves on this cycle
    assign load_s[DATA_WIDTH] = o_out.ready;

    genvar k;
    generate
        for (k = 0; k < DATA_WIDTH; k++) begin : g_stage
            assign load_s[k]       = ~valid_s[k+1] | load_s[k+1];
            assign ctrl_s[k].valid = valid_s[k];
            assign ctrl_s[k].load  = load_s[k];

            urd_stage #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (ctrl_s[k]),
                .i_rem   (rem_s[k]),
                .i_num   (num_s[k]),
                .i_den   (den_s[k]),
                .o_valid (valid_s[k+1]),
                .o_rem   (rem_s[k+1]),
                .o_num   (num_s[k+1]),
                .o_den   (den_s[k+1])
            );
        end
    endgenerate

    assign i_in.ready      = load_s[0];
    assign o_out.valid     = valid_s[DATA_WIDTH];
    assign o_out.quotient  = num_s[DATA_WIDTH];
    assign o_out.remainder = rem_s[DATA_WIDTH];

    // full pipeline with a stalled output takes no new beat
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&valid_s[DATA_WIDTH:1]) && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while pipeline full and stalled");

    // remainder below divisor unless the divisor is zero
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((den_s[DATA_WIDTH] == '0) ||
                         (o_out.remainder < den_s[DATA_WIDTH])))
        else $error("remainder not below divisor");

    // zero divisor gives all-ones quotient
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (den_s[DATA_WIDTH] == '0)) |-> (&o_out.quotient))
        else $error("zero divisor quotient not all ones");

    // an empty stage behind the output leaves a bubble after the beat leaves
    a_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !valid_s[DATA_WIDTH-1]) |=> !o_out.valid)
        else $error("result beat repeated or invented");

endmodule : unsigned_restoring_divider_core

`default_nettype wire

@@ rtl/core/urd_stage.sv @@
// One restoring division step with its pipeline register: one quotient bit.
// Depends on urd_pkg.
`default_nettype none

module urd_stage #(
    parameter int DATA_WIDTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  urd_pkg::t_stage_ctrl    i_ctrl,
    input  wire  [DATA_WIDTH-1:0]   i_rem,
    input  wire  [DATA_WIDTH-1:0]   i_num,
    input  wire  [DATA_WIDTH-1:0]   i_den,
    output logic                    o_valid,
    output logic [DATA_WIDTH-1:0]   o_rem,
    output logic [DATA_WIDTH-1:0]   o_num,
    output logic [DATA_WIDTH-1:0]   o_den
);
    import urd_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_num;
    logic [DATA_WIDTH-1:0] r_den;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_num;

    // shifted keeps the bit leaving the remainder as its top bit
    always_comb begin
        shifted = {i_rem, i_num[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, i_den};
        fits    = ~diff[DATA_WIDTH];
        n_rem   = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        n_num   = {i_num[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_den <= i_den;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule : urd_stage

`default_nettype wire
